FILE: hdl/lscp_pkg.sv
// shared types and constants of the line scan centroid pid block
`timescale 1ns / 1ps
package lscp_pkg;

   localparam int IDX_W      = 9;
   localparam int CNT_W      = 10;
   localparam int SUM_W      = 17;
   localparam int SAMPLE_W   = 12;
   localparam int CENTER_W   = 9;
   localparam int OFFSET_W   = 7;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 16;
   localparam int CENT_W     = 13;
   localparam int STEER_W    = 24;
   localparam int FRAC_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CMD       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PIXEL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_OFFSET   = 3'd6;

   localparam logic [SAMPLE_W-1:0] RST_PIXEL_THRESHOLD = 12'd41;
   localparam logic [CENTER_W-1:0] RST_TARGET_PIXEL    = 9'd147;
   localparam logic [OFFSET_W-1:0] RST_CENTER_OFFSET   = 7'd13;

   typedef struct packed {
      logic        [SAMPLE_W-1:0] pixel_threshold;
      logic signed [GAIN_W-1:0]   gain_prop;
      logic signed [GAIN_W-1:0]   gain_integ;
      logic signed [GAIN_W-1:0]   gain_deriv;
      logic signed [SPEED_W-1:0]  speed_cmd;
      logic        [CENTER_W-1:0] target_pixel;
      logic signed [OFFSET_W-1:0] center_offset;
   } cfg_type;

   // one finished scan line handed from front to back
   typedef struct packed {
      logic [CNT_W-1:0] hit_count;
      logic [SUM_W-1:0] moment_sum;
   } job_type;

endpackage

FILE: hdl/lscp_front.sv
// front end: thresholds pixels and sums hit count and index moment per line
`timescale 1ns / 1ps
module lscp_front
   import lscp_pkg::*;
#(
   parameter int MAX_PIXELS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [SAMPLE_W-1:0] pixel_sample,
   input  logic                last_pixel,
   input  logic [SAMPLE_W-1:0] pixel_threshold,
   input  logic                job_full,
   output logic                full,
   output logic                job_push,
   output job_type             job_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PIXELS - 1);

   logic [IDX_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic [SUM_W-1:0] moment_ff, moment_in;
   logic             overrun_ff, overrun_in;
   logic             accept;
   logic [CNT_W-1:0] hit_next;
   logic [SUM_W-1:0] moment_next;

   assign full   = job_full;
   assign accept = push && !job_full;

   always_comb begin
      hit_next    = hit_ff;
      moment_next = moment_ff;
      if (!overrun_ff && (pixel_sample > pixel_threshold)) begin
         hit_next    = hit_ff + CNT_W'(1);
         moment_next = moment_ff + SUM_W'(index_ff);
      end
   end

   always_comb begin
      index_in   = index_ff;
      hit_in     = hit_ff;
      moment_in  = moment_ff;
      overrun_in = overrun_ff;
      if (accept) begin
         if (last_pixel) begin
            index_in   = '0;
            hit_in     = '0;
            moment_in  = '0;
            overrun_in = 1'b0;
         end else begin
            hit_in    = hit_next;
            moment_in = moment_next;
            if (!overrun_ff) begin
               if (index_ff == LAST_IDX) begin
                  overrun_in = 1'b1;
               end else begin
                  index_in = index_ff + IDX_W'(1);
               end
            end
         end
      end
   end

   assign job_push            = accept && last_pixel;
   assign job_data.hit_count  = hit_next;
   assign job_data.moment_sum = moment_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         hit_ff     <= '0;
         moment_ff  <= '0;
         overrun_ff <= 1'b0;
      end else begin
         index_ff   <= index_in;
         hit_ff     <= hit_in;
         moment_ff  <= moment_in;
         overrun_ff <= overrun_in;
      end
   end

endmodule

FILE: hdl/lscp_job_fifo.sv
// two-entry queue of finished scan lines between front and back
`timescale 1ns / 1ps
module lscp_job_fifo
   import lscp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   job_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W_Q'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/lscp_back.sv
// back end: centroid divider, error, pid with one shared multiplier, result register
`timescale 1ns / 1ps
module lscp_back
   import lscp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      job_empty,
   input  job_type                   job_data,
   output logic                      job_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [STEER_W-1:0] rsp_steer_cmd,
   output logic signed [SPEED_W-1:0] rsp_speed_out,
   output logic [CENT_W-1:0]         rsp_line_centroid,
   output logic                      rsp_line_seen
);

   localparam int NUM_W   = SUM_W + FRAC_W + 1;
   localparam int STEP_W  = $clog2(NUM_W);
   localparam int ERR_W   = 16;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int MUL_B_W = STEER_W;
   localparam int PROD_W  = GAIN_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int RND_SH  = 8;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_ERR   = 3'd2;
   localparam logic [2:0] ST_MUL_P = 3'd3;
   localparam logic [2:0] ST_MUL_I = 3'd4;
   localparam logic [2:0] ST_MUL_D = 3'd5;
   localparam logic [2:0] ST_SUM   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   function automatic logic [STEER_W-1:0] sat_steer(input logic [ACC_W-1:0] x);
      logic [ACC_W-STEER_W:0] upper;
      upper = x[ACC_W-1:STEER_W-1];
      if ((&upper) || !(|upper)) begin
         return x[STEER_W-1:0];
      end else if (x[ACC_W-1]) begin
         return {1'b1, {(STEER_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STEER_W-1){1'b1}}};
      end
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]         divisor_ff, divisor_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     seen_ff, seen_in;
   logic [CENT_W-1:0]        cent_ff, cent_in;
   logic [ERR_W-1:0]         err_ff, err_in;
   logic [DIFF_W-1:0]        diff_ff, diff_in;
   logic [ERR_W-1:0]         prev_err_ff, prev_err_in;
   logic [STEER_W-1:0]       integ_ff, integ_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     out_valid_ff, out_valid_in;
   logic [STEER_W-1:0]       out_steer_ff, out_steer_in;
   logic [SPEED_W-1:0]       out_speed_ff, out_speed_in;
   logic [CENT_W-1:0]        out_cent_ff, out_cent_in;
   logic                     out_seen_ff, out_seen_in;

   logic [CNT_W:0]           trial;
   logic [ERR_W-1:0]         err_calc;
   logic [ACC_W-1:0]         isum;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [ACC_W-1:0]         prod_ext;
   logic [ACC_W-1:0]         rnd;
   logic                     out_free;

   assign trial    = {rem_ff, quot_ff[NUM_W-1]};
   assign out_free = !out_valid_ff || rsp_pop;

   // error in q.4: center - centroid + offset
   assign err_calc = {{(ERR_W-CENTER_W-FRAC_W){1'b0}}, cfg.target_pixel, {FRAC_W{1'b0}}}
                   - {{(ERR_W-CENT_W){1'b0}}, cent_ff}
                   + {{(ERR_W-OFFSET_W-FRAC_W){cfg.center_offset[OFFSET_W-1]}},
                      cfg.center_offset, {FRAC_W{1'b0}}};
   assign isum = {{(ACC_W-STEER_W){integ_ff[STEER_W-1]}}, integ_ff}
               + {{(ACC_W-ERR_W){err_calc[ERR_W-1]}}, err_calc};

   always_comb begin
      case (state_ff)
         ST_MUL_I: begin
            mul_a = cfg.gain_integ;
            mul_b = integ_ff;
         end
         ST_MUL_D: begin
            mul_a = cfg.gain_deriv;
            mul_b = {{(MUL_B_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         default: begin
            mul_a = cfg.gain_prop;
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign rnd      = acc_ff + ACC_W'(1 << (RND_SH - 1));

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      seen_in      = seen_ff;
      cent_in      = cent_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_steer_in = out_steer_ff;
      out_speed_in = out_speed_ff;
      out_cent_in  = out_cent_ff;
      out_seen_in  = out_seen_ff;
      job_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               rem_in     = '0;
               step_in    = '0;
               divisor_in = job_data.hit_count;
               seen_in    = (job_data.hit_count != '0);
               quot_in    = {1'b0, job_data.moment_sum, {FRAC_W{1'b0}}}
                          + NUM_W'(job_data.hit_count >> 1);
               cent_in    = '0;
               state_in   = (job_data.hit_count != '0) ? ST_DIV : ST_ERR;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in  = CNT_W'(trial - {1'b0, divisor_ff});
               quot_in = {quot_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[CNT_W-1:0];
               quot_in = {quot_ff[NUM_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               cent_in  = quot_in[CENT_W-1:0];
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in      = err_calc;
            diff_in     = {err_calc[ERR_W-1], err_calc} - {prev_err_ff[ERR_W-1], prev_err_ff};
            prev_err_in = err_calc;
            integ_in    = sat_steer(isum);
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            prod_in  = mul_p;
            acc_in   = '0;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + prod_ext;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + prod_ext;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_steer_in = sat_steer({{RND_SH{rnd[ACC_W-1]}}, rnd[ACC_W-1:RND_SH]});
               out_speed_in = cfg.speed_cmd;
               out_cent_in  = cent_ff;
               out_seen_in  = seen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      seen_ff      <= seen_in;
      cent_ff      <= cent_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      out_steer_ff <= out_steer_in;
      out_speed_ff <= out_speed_in;
      out_cent_ff  <= out_cent_in;
      out_seen_ff  <= out_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_steer_cmd     = out_steer_ff;
   assign rsp_speed_out     = out_speed_ff;
   assign rsp_line_centroid = out_cent_ff;
   assign rsp_line_seen     = out_seen_ff;

endmodule

FILE: hdl/line_scan_centroid_pid.sv
// top level of the line scan centroid pid block
`timescale 1ns / 1ps
// Pixels of a scan line enter one per clock on the req_ queue while req_full is
// low; a pixel above pixel_threshold adds its index to the line's moment and
// one to its hit count, and pixels past the first MAX_PIXELS of a line are
// ignored until last_pixel. The pixel with last_pixel set closes the line and
// hands its sums to a two-line queue; req_full rises only while that queue holds
// two lines. The back end then takes the line, runs a restoring divider for the
// Q9.4 centroid (skipped if no hits), finds error and integral, forms three
// products through a single 16x24 multiplier, rounds, saturates and waits while
// the result register is unpopped. So pixels stream at one per clock as long as
// lines average as many pixels as the back end spends cycles on a line. Each
// line gives one rsp_ item held in an output register until popped. Write csr_
// registers only while no line is in flight and the result queue is empty.
module line_scan_centroid_pid
   import lscp_pkg::*;
#(
   parameter int MAX_PIXELS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [SAMPLE_W-1:0]          req_pixel_sample,
   input  logic                         req_last_pixel,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [STEER_W-1:0]    rsp_steer_cmd,
   output logic signed [SPEED_W-1:0]    rsp_speed_out,
   output logic [CENT_W-1:0]            rsp_line_centroid,
   output logic                         rsp_line_seen,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cfg_type cfg_ff;
   logic    job_push, job_pop, job_full, job_empty;
   job_type job_in_data, job_out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_threshold <= RST_PIXEL_THRESHOLD;
         cfg_ff.gain_prop       <= '0;
         cfg_ff.gain_integ      <= '0;
         cfg_ff.gain_deriv      <= '0;
         cfg_ff.speed_cmd       <= '0;
         cfg_ff.target_pixel    <= RST_TARGET_PIXEL;
         cfg_ff.center_offset   <= RST_CENTER_OFFSET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_THRESHOLD: cfg_ff.pixel_threshold <= csr_wdata[SAMPLE_W-1:0];
            CSR_GAIN_PROP:       cfg_ff.gain_prop       <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_INTEG:      cfg_ff.gain_integ      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_DERIV:      cfg_ff.gain_deriv      <= csr_wdata[GAIN_W-1:0];
            CSR_SPEED_CMD:       cfg_ff.speed_cmd       <= csr_wdata[SPEED_W-1:0];
            CSR_TARGET_PIXEL:    cfg_ff.target_pixel    <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_OFFSET:   cfg_ff.center_offset   <= csr_wdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lscp_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .pixel_sample   (req_pixel_sample),
      .last_pixel     (req_last_pixel),
      .pixel_threshold(cfg_ff.pixel_threshold),
      .job_full       (job_full),
      .full           (req_full),
      .job_push       (job_push),
      .job_data       (job_in_data)
   );

   lscp_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(job_in_data),
      .pop      (job_pop),
      .full     (job_full),
      .empty    (job_empty),
      .pop_data (job_out_data)
   );

   lscp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .job_empty        (job_empty),
      .job_data         (job_out_data),
      .job_pop          (job_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_steer_cmd    (rsp_steer_cmd),
      .rsp_speed_out    (rsp_speed_out),
      .rsp_line_centroid(rsp_line_centroid),
      .rsp_line_seen    (rsp_line_seen)
   );

endmodule

FILE: hdl/lscp_checker.sv
// port-level checks of the line scan centroid pid block and their binding
`timescale 1ns / 1ps
module lscp_checker
   import lscp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input logic signed [STEER_W-1:0] rsp_steer_cmd,
   input logic signed [SPEED_W-1:0] rsp_speed_out,
   input logic [CENT_W-1:0]         rsp_line_centroid,
   input logic                      rsp_line_seen
);

   // reset leaves both queues open and empty
   a_reset_state: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");

   // a waiting item stays until popped
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result item dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_steer_cmd) && $stable(rsp_speed_out)
         && $stable(rsp_line_centroid) && $stable(rsp_line_seen))
      else $error("result item changed while waiting");

   // no line seen gives a zero centroid
   a_no_line_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_line_seen |-> rsp_line_centroid == '0)
      else $error("centroid nonzero without line");

endmodule

bind line_scan_centroid_pid lscp_checker u_lscp_checker (.*);

FILE: dv/line_scan_centroid_pid_test.sv
// self-checking testbench for the line scan centroid pid block
`timescale 1ns / 1ps
module line_scan_centroid_pid_test;
   import lscp_pkg::*;

   localparam int LINE_MAX    = 512;
   localparam int SETTLE_CYC  = 64;
   localparam int PARK_CYCLES = 500;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pix_value;
      logic                last;
   } scan_pixel_type;

   typedef struct packed {
      logic signed [STEER_W-1:0] steer;
      logic signed [SPEED_W-1:0] speed;
      logic [CENT_W-1:0]         centroid;
      logic                      seen;
   } steer_line_type;

   // short lines on reset settings, {value, last}
   localparam logic [12:0] OPEN_RESET [4] = '{
      {12'd41, 1'b0}, {12'd42, 1'b0}, {12'd0, 1'b1},
      {12'd0, 1'b1}
   };

   localparam logic [12:0] OPEN_TUNED [20] = '{
      {12'd4095, 1'b1},
      {12'd2000, 1'b0}, {12'd2001, 1'b0}, {12'd0, 1'b0}, {12'd4095, 1'b0}, {12'hAAA, 1'b1},
      {12'h555, 1'b0}, {12'd2001, 1'b0}, {12'd2001, 1'b1},
      {12'd0, 1'b0}, {12'd0, 1'b0}, {12'd0, 1'b1},
      {12'd4095, 1'b0}, {12'd4095, 1'b0}, {12'd4095, 1'b0}, {12'd4095, 1'b0},
      {12'd4095, 1'b1},
      {12'd2001, 1'b0}, {12'd0, 1'b0}, {12'd2001, 1'b1}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [SAMPLE_W-1:0]   req_pixel_sample = '0;
   logic                  req_last_pixel = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic signed [STEER_W-1:0] rsp_steer_cmd;
   logic signed [SPEED_W-1:0] rsp_speed_out;
   logic [CENT_W-1:0]     rsp_line_centroid;
   logic                  rsp_line_seen;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scan_pixel_type pixels_todo[$];
   steer_line_type steer_due[$];

   // predictor state
   cfg_type                   scan_cfg;
   logic [IDX_W-1:0]          pix_pos = '0;
   logic [CNT_W-1:0]          hits = '0;
   logic [SUM_W-1:0]          moment = '0;
   logic                      overrun = 1'b0;
   logic signed [15:0]        prev_err = '0;
   logic signed [STEER_W-1:0] integ = '0;

   int  send_idle = 0;
   int  take_idle = 0;
   int  mismatches = 0;
   int  lines_checked = 0;
   int  park_left = 0;
   bit  park_req = 1'b0;
   bit  park_done = 1'b0;

   line_scan_centroid_pid #(.MAX_PIXELS(LINE_MAX)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel_sample  (req_pixel_sample),
      .req_last_pixel    (req_last_pixel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_steer_cmd     (rsp_steer_cmd),
      .rsp_speed_out     (rsp_speed_out),
      .rsp_line_centroid (rsp_line_centroid),
      .rsp_line_seen     (rsp_line_seen),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp_steer(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic void advance_scan(scan_pixel_type px);
      longint         cent, err, diff, isum, acc;
      steer_line_type r;
      if (!overrun) begin
         if (px.pix_value > scan_cfg.pixel_threshold) begin
            hits   = hits + 1'b1;
            moment = moment + SUM_W'(pix_pos);
         end
         if (int'(pix_pos) + 1 >= LINE_MAX) overrun = 1'b1;
         else pix_pos = pix_pos + 1'b1;
      end
      if (px.last) begin
         cent = 0;
         if (hits != 0) begin
            cent = (longint'(moment) * 16 + longint'(hits) / 2) / longint'(hits);
         end
         err = longint'(scan_cfg.target_pixel) * 16 - cent
             + longint'(scan_cfg.center_offset) * 16;
         diff = err - longint'(prev_err);
         isum = clamp_steer(longint'(integ) + err);
         integ = STEER_W'(isum);
         acc = longint'(scan_cfg.gain_prop) * err + longint'(scan_cfg.gain_integ) * isum
             + longint'(scan_cfg.gain_deriv) * diff;
         // round half up to q.4, then saturate
         acc = clamp_steer((acc + 128) >>> 8);
         prev_err   = 16'(err);
         r.steer    = STEER_W'(acc);
         r.speed    = scan_cfg.speed_cmd;
         r.centroid = CENT_W'(cent);
         r.seen     = (hits != 0);
         steer_due.push_back(r);
         pix_pos = '0;
         hits    = '0;
         moment  = '0;
         overrun = 1'b0;
      end
   endfunction

   function automatic void check_line(steer_line_type got);
      steer_line_type want;
      lines_checked++;
      if (steer_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("line %0d: unexpected item steer %0d speed %0d centroid %0d seen %0d",
                     lines_checked, got.steer, got.speed, got.centroid, got.seen);
         end
         return;
      end
      want = steer_due.pop_front();
      if (got.steer !== want.steer || got.speed !== want.speed ||
          got.centroid !== want.centroid || got.seen !== want.seen) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("line %0d: expected steer %0d speed %0d centroid %0d seen %0d",
                     lines_checked, want.steer, want.speed, want.centroid, want.seen);
            $display("line %0d: actual   steer %0d speed %0d centroid %0d seen %0d",
                     lines_checked, got.steer, got.speed, got.centroid, got.seen);
         end
      end
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            advance_scan(pixels_todo.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (pixels_todo.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_push         <= 1'b1;
               req_pixel_sample <= pixels_todo[0].pix_value;
               req_last_pixel   <= pixels_todo[0].last;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_line('{steer: rsp_steer_cmd, speed: rsp_speed_out,
                         centroid: rsp_line_centroid, seen: rsp_line_seen});
         end
         if (park_req && !park_done) begin
            park_left <= PARK_CYCLES;
            park_done <= 1'b1;
            rsp_pop   <= 1'b0;
         end else if (park_left != 0) begin
            park_left <= park_left - 1;
            rsp_pop   <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= take_idle);
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PIXEL_THRESHOLD: scan_cfg.pixel_threshold = data[SAMPLE_W-1:0];
         CSR_GAIN_PROP:       scan_cfg.gain_prop       = data[GAIN_W-1:0];
         CSR_GAIN_INTEG:      scan_cfg.gain_integ      = data[GAIN_W-1:0];
         CSR_GAIN_DERIV:      scan_cfg.gain_deriv      = data[GAIN_W-1:0];
         CSR_SPEED_CMD:       scan_cfg.speed_cmd       = data[SPEED_W-1:0];
         CSR_TARGET_PIXEL:    scan_cfg.target_pixel    = data[CENTER_W-1:0];
         CSR_CENTER_OFFSET:   scan_cfg.center_offset   = data[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [SAMPLE_W-1:0] thr,
                                input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [SPEED_W-1:0] spd,
                                input logic [CENTER_W-1:0] ctr,
                                input logic [OFFSET_W-1:0] ofs);
      write_csr(CSR_PIXEL_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_GAIN_PROP, kp);
      write_csr(CSR_GAIN_INTEG, ki);
      write_csr(CSR_GAIN_DERIV, kd);
      write_csr(CSR_SPEED_CMD, spd);
      write_csr(CSR_TARGET_PIXEL, CSR_DATA_W'(ctr));
      write_csr(CSR_CENTER_OFFSET, {{(CSR_DATA_W-OFFSET_W){ofs[OFFSET_W-1]}}, ofs});
   endtask

   task automatic load_random();
      load_settings(SAMPLE_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                    GAIN_W'($urandom), SPEED_W'($urandom), CENTER_W'($urandom),
                    OFFSET_W'($urandom));
   endtask

   task automatic queue_line(input int len, input int dense);
      scan_pixel_type      px;
      int                  pick;
      logic [SAMPLE_W-1:0] thr;
      thr = scan_cfg.pixel_threshold;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 4) px.pix_value = '0;
         else if (pick < 8) px.pix_value = '1;
         else if (pick < 14) px.pix_value = thr;
         else if (pick < 20) px.pix_value = thr + 1'b1;
         else if (pick < 35) px.pix_value = SAMPLE_W'($urandom);
         else if ($urandom_range(99) < dense) px.pix_value = SAMPLE_W'($urandom_range(4095, thr));
         else px.pix_value = SAMPLE_W'($urandom_range(thr, 0));
         px.last = (i == len - 1);
         pixels_todo.push_back(px);
      end
   endtask

   task automatic queue_lines(input int budget, input bit long_first);
      int n, len;
      n = 0;
      if (long_first) begin
         // reaches or runs past the pixel limit of a line
         len = $urandom_range(530, 512);
         queue_line(len, 50);
         n = len;
      end
      while (n < budget) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(90, 41) : $urandom_range(40, 1);
         queue_line(len, $urandom_range(100, 0));
         n += len;
      end
   endtask

   task automatic settle();
      while (pixels_todo.size() != 0 || steer_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      scan_cfg = '{pixel_threshold: RST_PIXEL_THRESHOLD, gain_prop: '0, gain_integ: '0,
                   gain_deriv: '0, speed_cmd: '0, target_pixel: RST_TARGET_PIXEL,
                   center_offset: RST_CENTER_OFFSET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle = 24;
      take_idle = 60;
      foreach (OPEN_RESET[i]) pixels_todo.push_back(scan_pixel_type'(OPEN_RESET[i]));
      settle();
      load_settings(12'd2000, 16'h0100, 16'h0010, 16'hFF80, 16'h7FFF, 9'd256, 7'h40);
      foreach (OPEN_TUNED[i]) pixels_todo.push_back(scan_pixel_type'(OPEN_TUNED[i]));
      settle();

      // every nonzero pixel counts, gains at positive full scale
      load_settings(12'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 9'd511, 7'd63);
      park_req = 1'b1;
      queue_lines(250, 1'b0);
      settle();
      // no pixel can count, gains at negative full scale
      load_settings(12'hFFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 9'd0, 7'h40);
      queue_lines(250, 1'b0);
      settle();

      send_idle = 60;
      take_idle = 24;
      load_random();
      queue_lines(800, 1'b1);
      settle();
      load_random();
      queue_lines(150, 1'b0);
      settle();

      send_idle = 0;
      take_idle = 0;
      load_random();
      queue_lines(200, 1'b0);
      settle();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
